### rtl/vsp_pkg.sv
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared types, widths, register codes and the raised-cosine table for the
// velocity slew planner.
// ----------------------------------------------------------------------------
`default_nettype none

package vsp_pkg;

   // table and gain settings
   localparam int COS_TABLE_BITS = 8;
   localparam int SMOOTH_GAIN    = 10;
   localparam int ROM_LEN        = (1 << COS_TABLE_BITS) + 1;
   localparam int IDX_W          = COS_TABLE_BITS + 1;

   // field widths
   localparam int SPD_W      = 32;
   localparam int LIM_W      = 31;
   localparam int TICK_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_W      = 3 * SPD_W + TICK_W;
   localparam int RSP_W      = 3 * SPD_W;

   // datapath widths
   localparam int MBASE_W = LIM_W + TICK_W;
   localparam int M_W     = MBASE_W + $clog2(SMOOTH_GAIN + 1);
   localparam int WIDE_W  = M_W + 2;
   localparam int MAG_W   = SPD_W + 1;
   localparam int MUL_W   = MAG_W;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int FRAC_W  = 17;
   localparam int DIV_W   = 64;
   localparam int RATIO_W = 24;
   localparam int CNT_W   = 5;
   localparam int DIST_W  = SPD_W + 2;
   localparam int LIMS_W  = DIST_W + 2;
   localparam int EPS_Q16 = 66;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // register indexes
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_PLAN_MODE = 3'd0;
   localparam csr_addr_type CSR_ACCEL_X   = 3'd1;
   localparam csr_addr_type CSR_ACCEL_Y   = 3'd2;
   localparam csr_addr_type CSR_ACCEL_W   = 3'd3;
   localparam csr_addr_type CSR_STEP_THR  = 3'd4;
   localparam csr_addr_type CSR_BASE_LIM  = 3'd5;
   localparam csr_addr_type CSR_MAX_LIM   = 3'd6;

   // plan modes (codes 1 and 3 both select cosine)
   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_TRAP   = 2'd0;
   localparam mode_type MODE_SCURVE = 2'd2;

   // reset values
   localparam logic [LIM_W-1:0] RST_ACCEL_XY = 31'd2621440;
   localparam logic [LIM_W-1:0] RST_ACCEL_W  = 31'd1310720;
   localparam logic [LIM_W-1:0] RST_STEP_THR = 31'd1966080;
   localparam logic [LIM_W-1:0] RST_BASE_LIM = 31'd1966080;
   localparam logic [LIM_W-1:0] RST_MAX_LIM  = 31'd2621440;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_MUL,
      ST_MSCALE,
      ST_DEC,
      ST_DIV,
      ST_FMUL,
      ST_STEP,
      ST_VEC,
      ST_SQX,
      ST_SQY,
      ST_ROOTI,
      ST_ROOT,
      ST_LIMIT,
      ST_SCX,
      ST_SCY,
      ST_SCE
   } state_type;

   typedef logic [FRAC_W-1:0] rom_type [ROM_LEN];

   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

   // sin^2 table in Q16 from a Q30 Taylor series; last entry is exactly 1.0
   function automatic rom_type build_rom();
      rom_type            rom;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        s;
      logic [63:0]        f;
      logic signed [63:0] sum;
      for (int i = 0; i < ROM_LEN; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) >> COS_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int k = 0; k < 7; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         s = $unsigned(sum);
         if (s > (64'd1 << 30)) begin
            s = 64'd1 << 30;
         end
         f = (s * s + (64'd1 << 43)) >> 44;
         if (f > 64'd65535) begin
            f = 64'd65535;
         end
         rom[i] = FRAC_W'(f);
      end
      rom[ROM_LEN-1] = FRAC_W'(65536);
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   // clamp a wide two's complement value to signed 32 bits
   function automatic logic [SPD_W-1:0] sat32(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-SPD_W:0] hi;
      hi = v[WIDE_W-1:SPD_W-1];
      if (hi == '0 || hi == '1) begin
         return v[SPD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(SPD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SPD_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

### rtl/velocity_slew_planner_top.sv
// ----------------------------------------------------------------------------
// velocity_slew_planner_top
// Slew-rate limiter for x, y and yaw speeds with an x-y step-length clamp,
// built around one shared multiplier, a shift-subtract divider and a
// digit-by-digit square root under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  req     | in        | req_tvalid/req_tready  | target x, y, w speeds, ticks
//  rsp     | out       | rsp_tvalid/rsp_tready  | planned x, y, w speeds
//  csr     | in        | csr_wr_en              | csr_addr, csr_wdata
//
//  Each axis passes through the accel-by-ticks multiply, the scale and the
//  decision step; in cosine mode, when the step is limited, a 9-step
//  table-index divide and the factor multiply follow. The vector part runs
//  two squares, a 32-step root and the limit; when the step is clamped, a
//  24-step ratio divide, two scale multiplies and the y write-back follow
//  before the result is posted. The root loop is the longest fixed step.
//  After the post the block returns to idle and only there takes a request.
//  Reset is synchronous: held speeds clear and registers return to defaults.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and only the final post stalls on rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_slew_planner_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: target_speed_x, target_speed_y, target_speed_w, elapsed_ticks
   input  wire logic [vsp_pkg::REQ_W-1:0]        req_tdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: speed_out_x, speed_out_y, speed_out_w
   output logic [vsp_pkg::RSP_W-1:0]             rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_wr_en,
   input  wire logic [vsp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [vsp_pkg::LIM_W-1:0]        csr_wdata
);
   import vsp_pkg::*;

   localparam logic [CNT_W-1:0] IDX_LAST   = CNT_W'(IDX_W - 1);
   localparam logic [CNT_W-1:0] RATIO_LAST = CNT_W'(RATIO_W - 1);
   localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(SPD_W - 1);
   localparam logic [IDX_W-1:0] IDX_MAX    = IDX_W'(1 << COS_TABLE_BITS);

   // sequencer
   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   // configuration
   mode_type         mode_ff, mode_in;
   logic [LIM_W-1:0] accel_ff [3];
   logic [LIM_W-1:0] accel_in [3];
   logic [LIM_W-1:0] thr_ff, thr_in, base_ff, base_in, top_ff, top_in;

   // request and speed state
   logic [SPD_W-1:0]  tgt_ff [3];
   logic [SPD_W-1:0]  tgt_in [3];
   logic [SPD_W-1:0]  held_ff [3];
   logic [SPD_W-1:0]  held_in [3];
   logic [SPD_W-1:0]  new_ff [3];
   logic [SPD_W-1:0]  new_in [3];
   logic [TICK_W-1:0] ticks_ff, ticks_in;

   // axis step
   logic [M_W-1:0]   m_ff, m_in;
   logic [MAG_W-1:0] ad_ff, ad_in;
   logic             dneg_ff, dneg_in;

   // shared multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p_ff;

   // shared divider
   logic [DIV_W-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [RATIO_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ratio_div_ff, ratio_div_in;

   // square root
   logic [DIV_W-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;

   // vector clamp
   logic [MAG_W-1:0] magx_ff, magx_in, magy_ff, magy_in;
   logic             negx_ff, negx_in, negy_ff, negy_in, large_ff, large_in;

   // result register
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [SPD_W-1:0]     held_sel, tgt_sel;
   logic [MAG_W-1:0]     d_full, d_mag;
   logic [MBASE_W-1:0]   m_base;
   logic [M_W-1:0]       m_gain;
   logic [WIDE_W-1:0]    held_w, m_w, mstep_r, cstep_r;
   logic                 big, over_eps;
   logic [MAG_W+FRAC_W:0] step_sum;
   logic [IDX_W-1:0]     idx_raw, idx_c;
   logic [FRAC_W-1:0]    frac;
   logic                 div_ge, div_last;
   logic [MAG_W-1:0]     dx_full, dy_full, sq_x, sq_y;
   logic [DIV_W-1:0]     root_t;
   logic                 root_ge;
   logic [DIST_W-1:0]    vec_len;
   logic signed [LIMS_W-1:0] dist_s, thr_s, base_s, top_s, ramp_top, limit_s;
   logic [MAG_W+RATIO_W:0]   sc_sum;
   logic [SPD_W-1:0]     sc_prev;
   logic                 sc_neg;
   logic [WIDE_W-1:0]    sc_prev_w, sc_r;

   assign held_sel = held_ff[axis_ff];
   assign tgt_sel  = tgt_ff[axis_ff];
   assign d_full   = {tgt_sel[SPD_W-1], tgt_sel} - {held_sel[SPD_W-1], held_sel};
   assign d_mag    = d_full[MAG_W-1] ? (~d_full + MAG_W'(1)) : d_full;
   assign m_base   = mul_p_ff[MBASE_W-1:0];
   assign m_gain   = M_W'(m_base) * M_W'(SMOOTH_GAIN);

   assign held_w   = {{(WIDE_W-SPD_W){held_sel[SPD_W-1]}}, held_sel};
   assign m_w      = WIDE_W'(m_ff);
   assign mstep_r  = dneg_ff ? (held_w - m_w) : (held_w + m_w);
   assign big      = M_W'(ad_ff) > m_ff;
   assign over_eps = ad_ff > MAG_W'(EPS_Q16);

   // step = (|d| * f + 0.5) >> 16
   assign step_sum = (MAG_W+FRAC_W+1)'(mul_p_ff[MAG_W+FRAC_W-1:0])
                     + (MAG_W+FRAC_W+1)'(1 << 15);
   assign cstep_r  = dneg_ff ? (held_w - WIDE_W'(step_sum[MAG_W+FRAC_W:16]))
                             : (held_w + WIDE_W'(step_sum[MAG_W+FRAC_W:16]));

   assign idx_raw  = q_ff[IDX_W-1:0];
   assign idx_c    = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
   assign frac     = COS_ROM[idx_c];

   assign div_ge   = rem_ff >= den_ff;
   assign div_last = cnt_ff == (ratio_div_ff ? RATIO_LAST : IDX_LAST);

   assign dx_full  = {new_ff[0][SPD_W-1], new_ff[0]} - {held_ff[0][SPD_W-1], held_ff[0]};
   assign dy_full  = {new_ff[1][SPD_W-1], new_ff[1]} - {held_ff[1][SPD_W-1], held_ff[1]};
   assign sq_x     = large_ff ? (magx_ff >> 2) : magx_ff;
   assign sq_y     = large_ff ? (magy_ff >> 2) : magy_ff;

   assign root_t   = res_ff + bit_ff;
   assign root_ge  = v_ff >= root_t;

   // piecewise-linear step limit
   assign vec_len  = large_ff ? {res_ff[SPD_W-1:0], 2'b00} : {2'b00, res_ff[SPD_W-1:0]};
   assign dist_s   = $signed(LIMS_W'(vec_len));
   assign thr_s    = $signed(LIMS_W'(thr_ff));
   assign base_s   = $signed(LIMS_W'(base_ff));
   assign top_s    = $signed(LIMS_W'(top_ff));
   assign ramp_top = thr_s + ((top_s - base_s) <<< 1);

   always_comb begin
      if (dist_s <= thr_s) begin
         limit_s = thr_s;
      end else if (dist_s <= ramp_top) begin
         limit_s = base_s + ((dist_s - thr_s) >>> 1);
      end else begin
         limit_s = top_s;
      end
   end

   // scaled delta, rounded at bit 24
   assign sc_sum    = (MAG_W+RATIO_W+1)'(mul_p_ff[MAG_W+RATIO_W-1:0])
                      + (MAG_W+RATIO_W+1)'(1 << 23);
   assign sc_prev   = (state_ff == ST_SCY) ? held_ff[0] : held_ff[1];
   assign sc_neg    = (state_ff == ST_SCY) ? negx_ff : negy_ff;
   assign sc_prev_w = {{(WIDE_W-SPD_W){sc_prev[SPD_W-1]}}, sc_prev};
   assign sc_r      = sc_neg ? (sc_prev_w - WIDE_W'(sc_sum[MAG_W+RATIO_W:24]))
                             : (sc_prev_w + WIDE_W'(sc_sum[MAG_W+RATIO_W:24]));

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      mode_in      = mode_ff;
      accel_in     = accel_ff;
      thr_in       = thr_ff;
      base_in      = base_ff;
      top_in       = top_ff;
      tgt_in       = tgt_ff;
      held_in      = held_ff;
      new_in       = new_ff;
      ticks_in     = ticks_ff;
      m_in         = m_ff;
      ad_in        = ad_ff;
      dneg_in      = dneg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      ratio_div_in = ratio_div_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      magx_in      = magx_ff;
      magy_in      = magy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      large_in     = large_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         case (csr_addr)
            CSR_PLAN_MODE: mode_in     = csr_wdata[MODE_W-1:0];
            CSR_ACCEL_X:   accel_in[0] = csr_wdata;
            CSR_ACCEL_Y:   accel_in[1] = csr_wdata;
            CSR_ACCEL_W:   accel_in[2] = csr_wdata;
            CSR_STEP_THR:  thr_in      = csr_wdata;
            CSR_BASE_LIM:  base_in     = csr_wdata;
            CSR_MAX_LIM:   top_in      = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               tgt_in[0] = req_tdata[SPD_W-1:0];
               tgt_in[1] = req_tdata[2*SPD_W-1:SPD_W];
               tgt_in[2] = req_tdata[3*SPD_W-1:2*SPD_W];
               ticks_in  = req_tdata[REQ_W-1:3*SPD_W];
               axis_in   = 2'd0;
               state_in  = ST_ACC_MUL;
            end
         end
         ST_ACC_MUL: begin
            mul_a    = MUL_W'(accel_ff[axis_ff]);
            mul_b    = MUL_W'(ticks_ff);
            state_in = ST_MSCALE;
         end
         ST_MSCALE: begin
            m_in     = (mode_ff == MODE_TRAP) ? M_W'(m_base) : m_gain;
            ad_in    = d_mag;
            dneg_in  = d_full[MAG_W-1];
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (mode_ff == MODE_TRAP) begin
               new_in[axis_ff] = big ? sat32(mstep_r) : tgt_sel;
            end else if (!(over_eps && big)) begin
               new_in[axis_ff] = tgt_sel;
            end else if (mode_ff == MODE_SCURVE) begin
               new_in[axis_ff] = sat32(mstep_r);
            end
            if ((mode_ff != MODE_TRAP) && (mode_ff != MODE_SCURVE) && over_eps && big) begin
               // index = round(m * 2^B / |d|) as (2m*2^B + |d|) / (2|d|)
               rem_in       = (DIV_W'(m_ff) << IDX_W) + DIV_W'(ad_ff);
               den_in       = DIV_W'(ad_ff) << IDX_W;
               q_in         = '0;
               cnt_in       = '0;
               ratio_div_in = 1'b0;
               state_in     = ST_DIV;
            end else if (axis_ff == 2'd2) begin
               state_in = ST_VEC;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_ACC_MUL;
            end
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - den_ff;
            end
            q_in   = {q_ff[RATIO_W-2:0], div_ge};
            den_in = den_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ratio_div_ff ? ST_SCX : ST_FMUL;
            end
         end
         ST_FMUL: begin
            mul_a    = ad_ff;
            mul_b    = MUL_W'(frac);
            state_in = ST_STEP;
         end
         ST_STEP: begin
            new_in[axis_ff] = sat32(cstep_r);
            if (axis_ff == 2'd2) begin
               state_in = ST_VEC;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_ACC_MUL;
            end
         end
         ST_VEC: begin
            negx_in  = dx_full[MAG_W-1];
            negy_in  = dy_full[MAG_W-1];
            magx_in  = dx_full[MAG_W-1] ? (~dx_full + MAG_W'(1)) : dx_full;
            magy_in  = dy_full[MAG_W-1] ? (~dy_full + MAG_W'(1)) : dy_full;
            large_in = 1'b0;
            if (dx_full[MAG_W-1]) begin
               large_in = (~dx_full + MAG_W'(1)) >= (MAG_W'(1) << 31);
            end else begin
               large_in = dx_full >= (MAG_W'(1) << 31);
            end
            if (dy_full[MAG_W-1]) begin
               large_in = large_in || ((~dy_full + MAG_W'(1)) >= (MAG_W'(1) << 31));
            end else begin
               large_in = large_in || (dy_full >= (MAG_W'(1) << 31));
            end
            state_in = ST_SQX;
         end
         ST_SQX: begin
            mul_a    = sq_x;
            mul_b    = sq_x;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            v_in     = DIV_W'(mul_p_ff);
            mul_a    = sq_y;
            mul_b    = sq_y;
            state_in = ST_ROOTI;
         end
         ST_ROOTI: begin
            v_in     = v_ff + DIV_W'(mul_p_ff);
            res_in   = '0;
            bit_in   = DIV_W'(1) << 62;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_ge) begin
               v_in   = v_ff - root_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            if (dist_s > limit_s) begin
               // ratio = limit * 2^24 / dist, below 2^24 since limit < dist
               rem_in       = DIV_W'(limit_s[LIM_W-1:0]) << RATIO_W;
               den_in       = DIV_W'(vec_len) << (RATIO_W - 1);
               q_in         = '0;
               cnt_in       = '0;
               ratio_div_in = 1'b1;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_SCE;
            end
         end
         ST_SCX: begin
            mul_a    = magx_ff;
            mul_b    = MUL_W'(q_ff);
            state_in = ST_SCY;
         end
         ST_SCY: begin
            new_in[0] = sat32(sc_r);
            mul_a     = magy_ff;
            mul_b     = MUL_W'(q_ff);
            state_in  = ST_SCE;
         end
         ST_SCE: begin
            // ratio_div_ff still set here means the y scale is pending
            if (ratio_div_ff) begin
               new_in[1]    = sat32(sc_r);
               ratio_div_in = 1'b0;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {new_ff[2], new_ff[1], new_ff[0]};
               rsp_valid_in = 1'b1;
               held_in      = new_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         mode_ff      <= MODE_TRAP;
         accel_ff[0]  <= RST_ACCEL_XY;
         accel_ff[1]  <= RST_ACCEL_XY;
         accel_ff[2]  <= RST_ACCEL_W;
         thr_ff       <= RST_STEP_THR;
         base_ff      <= RST_BASE_LIM;
         top_ff       <= RST_MAX_LIM;
         held_ff[0]   <= '0;
         held_ff[1]   <= '0;
         held_ff[2]   <= '0;
         rsp_valid_ff <= 1'b0;
         ratio_div_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         mode_ff      <= mode_in;
         accel_ff     <= accel_in;
         thr_ff       <= thr_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         ratio_div_ff <= ratio_div_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      new_ff      <= new_in;
      ticks_ff    <= ticks_in;
      m_ff        <= m_in;
      ad_ff       <= ad_in;
      dneg_ff     <= dneg_in;
      mul_p_ff    <= PROD_W'(mul_a) * PROD_W'(mul_b);
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      v_ff        <= v_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      magx_ff     <= magx_in;
      magy_ff     <= magy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      large_ff    <= large_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
